// ===== rtl/bbmp_pkg.sv =====
// Package: shared types and constants of the bracket markup parser.
`timescale 1ns / 1ps
`default_nettype none
package bbmp_pkg;

    typedef enum logic [2:0] {
        M_NORMAL     = 3'd0,
        M_PEND_OPEN  = 3'd1,
        M_PEND_CLOSE = 3'd2,
        M_NAME       = 3'd3,
        M_PARAMS     = 3'd4,
        M_CLOSING    = 3'd5,
        M_SWALLOW    = 3'd6
    } mode_t;

    localparam logic [2:0] K_TEXT  = 3'd0;
    localparam logic [2:0] K_NAME  = 3'd1;
    localparam logic [2:0] K_PARAM = 3'd2;
    localparam logic [2:0] K_OPEN  = 3'd3;
    localparam logic [2:0] K_CLOSE = 3'd4;
    localparam logic [2:0] K_DONE  = 3'd5;
    localparam logic [2:0] K_ERROR = 3'd6;

    localparam logic [3:0] E_STRAY      = 4'd0;
    localparam logic [3:0] E_EMPTY      = 4'd1;
    localparam logic [3:0] E_NAME_START = 4'd2;
    localparam logic [3:0] E_NAME_CHAR  = 4'd3;
    localparam logic [3:0] E_CLOSE_CHAR = 4'd4;
    localparam logic [3:0] E_UNEXPECTED = 4'd5;
    localparam logic [3:0] E_MISMATCH   = 4'd6;
    localparam logic [3:0] E_INCOMPLETE = 4'd7;
    localparam logic [3:0] E_UNCLOSED   = 4'd8;
    localparam logic [3:0] E_TOO_LONG   = 4'd9;
    localparam logic [3:0] E_TOO_DEEP   = 4'd10;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  event_byte;
        logic        starts_param;
        logic [3:0]  nest_level;
        logic [3:0]  error_code;
        logic [15:0] error_position;
        logic        last_of_run;
    } evt_t;

    typedef struct packed {
        logic v0;
        logic v1;
    } push_t;

endpackage
`default_nettype wire

// ===== rtl/bbmp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bbmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bbmp_result_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bbmp_result_fifo
    import bbmp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    input  wire evt_t  d0,
    input  wire evt_t  d1,
    output logic       full2,
    output logic       evt_valid,
    input  wire logic  evt_stall,
    output evt_t       evt_data
);
    evt_t       q_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [2:0] n_push;

    assign pop       = evt_valid && !evt_stall;
    assign evt_valid = (cnt_reg != 3'd0);
    assign evt_data  = q_reg[rp_reg];
    assign full2     = (cnt_reg > 3'd2);
    assign n_push    = {2'b00, push.v0} + {2'b00, push.v1};

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            q_reg[wp_reg] <= d0;
        end
        if (push.v1)
        begin
            q_reg[wp_reg + 2'd1] <= d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + n_push[1:0];
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + n_push - {2'b00, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bbcode_markup_parser_unit.sv =====
// Top level: streaming bracket markup parser with a RAM name stack.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_stall | req_data (char_byte, end_of_text)
//  evt     | out | evt_valid / evt_stall | evt_data (event fields)
//
// One byte per cycle while req_stall is low; each byte yields zero to two events that go
// into a four-entry queue. req_stall rises while fewer than two slots are free.
// The name stack RAM is read ahead, with the address taken from the next parser
// state, so its registered read data is ready for the closing-name compare.
// rst_n clears the parser state and the queue; the RAM needs no clearing.
// The last byte of a text restarts the parser at position zero.
`timescale 1ns / 1ps
`default_nettype none
module bbcode_markup_parser_unit
    import bbmp_pkg::*;
#(
    parameter int STACK_DEPTH = 8,
    parameter int NAME_LEN    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      evt_valid,
    input  wire logic evt_stall,
    output evt_t      evt_data
);
    localparam int DEPTH = STACK_DEPTH * NAME_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(STACK_DEPTH + 1);
    localparam int LIW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW    = $clog2(NAME_LEN + 1);

    // Parser state
    mode_t          mode_reg, mode_next;
    logic [LW-1:0]  open_reg, open_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic           mis_reg, mis_next;
    logic           gap_reg, gap_next;
    logic [15:0]    pos_reg, pos_next;
    logic [15:0]    pend_reg, pend_next;
    logic [NW-1:0]  len_reg [STACK_DEPTH];

    logic           len_we, len_clr;
    logic [LIW-1:0] len_wi;

    logic           acc, full2;
    logic [7:0]     c;
    logic           last;
    push_t          push;
    evt_t           e0, e1;

    logic           wr_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [7:0]     rd_data;
    logic [LW-1:0]  rd_top;
    logic [NW-1:0]  rd_idx;
    logic [LIW-1:0] top;

    assign req_stall = full2;
    assign acc       = req_valid && !req_stall;
    assign c         = req_data.char_byte;
    assign last      = req_data.end_of_text;
    assign top       = (open_reg == '0) ? '0 : LIW'(open_reg - LW'(1));

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_namech(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic evt_t mk(input logic [2:0] k, input logic [7:0] b, input logic sp,
                                input logic [LW-1:0] n, input logic [3:0] er,
                                input logic [15:0] p);
        evt_t r;
        r.event_kind     = k;
        r.event_byte     = b;
        r.starts_param   = sp;
        r.nest_level     = 4'(n);
        r.error_code     = er;
        r.error_position = p;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic v0, v1;
        logic [LW-1:0] open_s;
        mode_next = mode_reg;
        open_next = open_reg;
        idx_next  = idx_reg;
        mis_next  = mis_reg;
        gap_next  = gap_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        len_we    = 1'b0;
        len_clr   = 1'b0;
        len_wi    = open_reg[LIW-1:0];
        wr_en     = 1'b0;
        wr_addr   = AW'(open_reg) * AW'(NAME_LEN) + AW'(idx_reg);
        v0        = 1'b0;
        v1        = 1'b0;
        e0        = mk(K_TEXT, 8'd0, 1'b0, open_reg, E_STRAY, 16'd0);
        e1        = e0;
        open_s    = open_reg;
        if (acc)
        begin
            unique case (mode_reg)
                M_NORMAL:
                begin
                    if (c == CH_OPEN)
                    begin
                        mode_next = M_PEND_OPEN;
                    end
                    else if (c == CH_CLOSE)
                    begin
                        mode_next = M_PEND_CLOSE;
                        pend_next = pos_reg;
                    end
                    else
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_TEXT, c, 1'b0, open_s, 4'd0, 16'd0);
                    end
                end
                M_PEND_OPEN:
                begin
                    priority if (c == CH_OPEN)
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_TEXT, c, 1'b0, open_s, 4'd0, 16'd0);
                        mode_next = M_NORMAL;
                    end
                    else if (c == CH_SLASH)
                    begin
                        mode_next = M_CLOSING;
                        idx_next  = '0;
                        mis_next  = 1'b0;
                    end
                    else if (c == CH_CLOSE)
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_EMPTY, pos_reg);
                        mode_next = M_SWALLOW;
                    end
                    else if (is_alpha(c) || c == CH_UNDER)
                    begin
                        if (open_reg >= LW'(STACK_DEPTH))
                        begin
                            v0 = 1'b1;
                            e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_TOO_DEEP, pos_reg);
                            mode_next = M_SWALLOW;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = AW'(open_reg) * AW'(NAME_LEN);
                            idx_next  = NW'(1);
                            mode_next = M_NAME;
                            v0 = 1'b1;
                            e0 = mk(K_NAME, c, 1'b0, open_s, 4'd0, 16'd0);
                        end
                    end
                    else
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_NAME_START, pos_reg);
                        mode_next = M_SWALLOW;
                    end
                end
                M_PEND_CLOSE:
                begin
                    v0 = 1'b1;
                    if (c == CH_CLOSE)
                    begin
                        e0 = mk(K_TEXT, c, 1'b0, open_s, 4'd0, 16'd0);
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_STRAY, pend_reg);
                        mode_next = M_SWALLOW;
                    end
                end
                M_NAME, M_PARAMS:
                begin
                    priority if (c == CH_CLOSE)
                    begin
                        if (open_reg < LW'(STACK_DEPTH))
                        begin
                            len_we = 1'b1;
                            open_s = open_reg + LW'(1);
                        end
                        v0 = 1'b1;
                        e0 = mk(K_OPEN, 8'd0, 1'b0, open_s, 4'd0, 16'd0);
                        mode_next = M_NORMAL;
                    end
                    else if (mode_reg == M_PARAMS)
                    begin
                        if (is_space(c))
                        begin
                            gap_next = 1'b1;
                        end
                        else
                        begin
                            v0 = 1'b1;
                            e0 = mk(K_PARAM, c, gap_reg, open_s, 4'd0, 16'd0);
                            gap_next = 1'b0;
                        end
                    end
                    else if (c == CH_SPACE)
                    begin
                        mode_next = M_PARAMS;
                        gap_next  = 1'b1;
                    end
                    else if (is_namech(c))
                    begin
                        v0 = 1'b1;
                        if (idx_reg >= NW'(NAME_LEN) || open_reg >= LW'(STACK_DEPTH))
                        begin
                            e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_TOO_LONG, pos_reg);
                            mode_next = M_SWALLOW;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            idx_next = idx_reg + NW'(1);
                            e0 = mk(K_NAME, c, 1'b0, open_s, 4'd0, 16'd0);
                        end
                    end
                    else
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_NAME_CHAR, pos_reg);
                        mode_next = M_SWALLOW;
                    end
                end
                M_CLOSING:
                begin
                    priority if (c == CH_CLOSE)
                    begin
                        v0 = 1'b1;
                        if (open_reg == '0)
                        begin
                            e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_UNEXPECTED, pos_reg);
                            mode_next = M_SWALLOW;
                        end
                        else if (mis_reg || idx_reg != len_reg[top])
                        begin
                            e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_MISMATCH, pos_reg);
                            mode_next = M_SWALLOW;
                        end
                        else
                        begin
                            open_s = open_reg - LW'(1);
                            e0 = mk(K_CLOSE, 8'd0, 1'b0, open_s, 4'd0, 16'd0);
                            mode_next = M_NORMAL;
                        end
                    end
                    else if (is_namech(c))
                    begin
                        if (open_reg == '0 || idx_reg >= len_reg[top]
                            || idx_reg >= NW'(NAME_LEN) || rd_data != c)
                        begin
                            mis_next = 1'b1;
                        end
                        if (idx_reg < NW'(NAME_LEN))
                        begin
                            idx_next = idx_reg + NW'(1);
                        end
                    end
                    else
                    begin
                        v0 = 1'b1;
                        e0 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_CLOSE_CHAR, pos_reg);
                        mode_next = M_SWALLOW;
                    end
                end
                default:
                begin
                    mode_next = M_SWALLOW;
                end
            endcase
            open_next = open_s;

            if (last)
            begin
                if (mode_next != M_SWALLOW)
                begin
                    v1 = 1'b1;
                    priority if (mode_next == M_PEND_CLOSE)
                        e1 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_STRAY, pend_next);
                    else if (mode_next != M_NORMAL)
                        e1 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_INCOMPLETE, pos_reg);
                    else if (open_s != '0)
                        e1 = mk(K_ERROR, 8'd0, 1'b0, open_s, E_UNCLOSED, pos_reg);
                    else
                        e1 = mk(K_DONE, 8'd0, 1'b0, open_s, 4'd0, 16'd0);
                end
                mode_next = M_NORMAL;
                open_next = '0;
                idx_next  = '0;
                mis_next  = 1'b0;
                gap_next  = 1'b1;
                pos_next  = '0;
                pend_next = '0;
                len_clr   = 1'b1;
            end
            else if (pos_reg != 16'hFFFF)
            begin
                pos_next = pos_reg + 16'd1;
            end

            // Pack the events so the first slot always fills first.
            if (v1 && !v0)
            begin
                e0 = e1;
                v0 = 1'b1;
                v1 = 1'b0;
            end
            if (v1)
                e1.last_of_run = 1'b1;
            else
                e0.last_of_run = 1'b1;
        end
        push.v0 = v0;
        push.v1 = v1;
    end

    // Read ahead: address from the next state, data lines up with the next byte.
    assign rd_top  = (open_next == '0) ? '0 : open_next - LW'(1);
    assign rd_idx  = (idx_next >= NW'(NAME_LEN)) ? '0 : idx_next;
    assign rd_addr = AW'(rd_top) * AW'(NAME_LEN) + AW'(rd_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
            open_reg <= '0;
            idx_reg  <= '0;
            mis_reg  <= 1'b0;
            gap_reg  <= 1'b1;
            pos_reg  <= '0;
            pend_reg <= '0;
            for (int i = 0; i < STACK_DEPTH; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            open_reg <= open_next;
            idx_reg  <= idx_next;
            mis_reg  <= mis_next;
            gap_reg  <= gap_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            if (len_clr)
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    len_reg[i] <= '0;
            end
            else if (len_we)
            begin
                len_reg[len_wi] <= idx_reg;
            end
        end
    end

    bbmp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_names (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (c),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bbmp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .d0        (e0),
        .d1        (e1),
        .full2     (full2),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data)
    );

`ifndef SYNTHESIS
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= LW'(STACK_DEPTH))
        else $error("open tag count past stack depth");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        acc && last |=> mode_reg == M_NORMAL && pos_reg == 16'd0 && open_reg == '0)
        else $error("parser did not restart after last byte");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_data.event_kind == K_DONE || evt_data.event_kind == K_ERROR)
        |-> evt_data.last_of_run)
        else $error("done or error event not last of its run");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench: bracket markup parser, checked event by event against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bbmp_pkg::*;

    localparam int DEPTH    = 8;
    localparam int NAME_MAX = 16;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic evt_valid;
    logic evt_stall = 1'b0;
    evt_t evt_data;

    bbcode_markup_parser_unit #(.STACK_DEPTH(DEPTH), .NAME_LEN(NAME_MAX)) uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .evt_valid(evt_valid), .evt_stall(evt_stall), .evt_data(evt_data)
    );

    always #5 clk = ~clk;

    // Pending requests, filled up front; expected events, filled as requests are accepted.
    req_t pending_reqs[$];
    evt_t expected_events[$];
    int   errors = 0;
    int   events_seen = 0;
    int   texts_sent = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off_now = 1'b0;

    // Predictor state: a private copy of the parser.
    mode_t       p_mode;
    logic [7:0]  p_names[DEPTH * NAME_MAX];
    int          p_len[DEPTH];
    int          p_open;
    int          p_idx;
    bit          p_mismatch;
    bit          p_gap;
    int          p_pos;
    int          p_pend_pos;
    evt_t        step_events[$];

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic restart_parser();
        p_mode = M_NORMAL;
        p_open = 0;
        p_idx = 0;
        p_mismatch = 1'b0;
        p_gap = 1'b1;
        p_pos = 0;
        p_pend_pos = 0;
        for (int i = 0; i < DEPTH; i++) p_len[i] = 0;
    endtask

    task automatic add_event(logic [2:0] kind, logic [7:0] b, bit sp, logic [3:0] code,
                             int position);
        evt_t e;
        e = '0;
        e.event_kind = kind;
        e.event_byte = b;
        e.starts_param = sp;
        e.nest_level = p_open[3:0];
        e.error_code = code;
        e.error_position = position > 65535 ? 16'hFFFF : position[15:0];
        if (step_events.size() < 2) step_events.insert(step_events.size(), e);
    endtask

    task automatic raise_error(logic [3:0] code, int position);
        add_event(K_ERROR, 8'd0, 1'b0, code, position);
        p_mode = M_SWALLOW;
    endtask

    task automatic open_tag();
        if (p_open < DEPTH) begin
            p_len[p_open] = p_idx;
            p_open++;
        end
        add_event(K_OPEN, 8'd0, 1'b0, 4'd0, 0);
        p_mode = M_NORMAL;
    endtask

    // Advance the predictor by one byte and queue the events it causes.
    task automatic predict_markup_events(req_t r);
        logic [7:0] c;
        int position;
        int top;
        c = r.char_byte;
        position = p_pos;
        step_events.delete();
        case (p_mode)
            M_NORMAL:
                if (c == CH_OPEN) p_mode = M_PEND_OPEN;
                else if (c == CH_CLOSE) begin
                    p_mode = M_PEND_CLOSE;
                    p_pend_pos = position;
                end
                else add_event(K_TEXT, c, 1'b0, 4'd0, 0);
            M_PEND_OPEN:
                if (c == CH_OPEN) begin
                    add_event(K_TEXT, c, 1'b0, 4'd0, 0);
                    p_mode = M_NORMAL;
                end
                else if (c == CH_SLASH) begin
                    p_mode = M_CLOSING;
                    p_idx = 0;
                    p_mismatch = 1'b0;
                end
                else if (c == CH_CLOSE) raise_error(E_EMPTY, position);
                else if (is_letter(c) || c == CH_UNDER) begin
                    if (p_open >= DEPTH) raise_error(E_TOO_DEEP, position);
                    else begin
                        p_names[p_open * NAME_MAX] = c;
                        p_idx = 1;
                        p_mode = M_NAME;
                        add_event(K_NAME, c, 1'b0, 4'd0, 0);
                    end
                end
                else raise_error(E_NAME_START, position);
            M_PEND_CLOSE:
                if (c == CH_CLOSE) begin
                    add_event(K_TEXT, c, 1'b0, 4'd0, 0);
                    p_mode = M_NORMAL;
                end
                else raise_error(E_STRAY, p_pend_pos);
            M_NAME:
                if (c == CH_SPACE) begin
                    p_mode = M_PARAMS;
                    p_gap = 1'b1;
                end
                else if (c == CH_CLOSE) open_tag();
                else if (is_name_char(c)) begin
                    if (p_idx >= NAME_MAX || p_open >= DEPTH) raise_error(E_TOO_LONG, position);
                    else begin
                        p_names[p_open * NAME_MAX + p_idx] = c;
                        p_idx++;
                        add_event(K_NAME, c, 1'b0, 4'd0, 0);
                    end
                end
                else raise_error(E_NAME_CHAR, position);
            M_PARAMS:
                if (c == CH_CLOSE) open_tag();
                else if (is_blank(c)) p_gap = 1'b1;
                else begin
                    add_event(K_PARAM, c, p_gap, 4'd0, 0);
                    p_gap = 1'b0;
                end
            M_CLOSING:
                if (c == CH_CLOSE) begin
                    if (p_open == 0) raise_error(E_UNEXPECTED, position);
                    else if (p_mismatch || p_idx != p_len[p_open - 1])
                        raise_error(E_MISMATCH, position);
                    else begin
                        p_open--;
                        add_event(K_CLOSE, 8'd0, 1'b0, 4'd0, 0);
                        p_mode = M_NORMAL;
                    end
                end
                else if (is_name_char(c)) begin
                    // Compare against the top name; never read past its stored length.
                    if (p_open == 0) p_mismatch = 1'b1;
                    else begin
                        top = p_open - 1;
                        if (p_idx >= p_len[top] || p_idx >= NAME_MAX) p_mismatch = 1'b1;
                        else if (p_names[top * NAME_MAX + p_idx] != c) p_mismatch = 1'b1;
                    end
                    if (p_idx < NAME_MAX) p_idx++;
                end
                else raise_error(E_CLOSE_CHAR, position);
            default: p_mode = M_SWALLOW;
        endcase
        if (r.end_of_text) begin
            if (p_mode != M_SWALLOW) begin
                if (p_mode == M_PEND_CLOSE) raise_error(E_STRAY, p_pend_pos);
                else if (p_mode != M_NORMAL) raise_error(E_INCOMPLETE, position);
                else if (p_open != 0) raise_error(E_UNCLOSED, position);
                else add_event(K_DONE, 8'd0, 1'b0, 4'd0, 0);
            end
            restart_parser();
        end
        else if (p_pos < 65535) p_pos++;
        if (step_events.size() > 0) step_events[step_events.size() - 1].last_of_run = 1'b1;
        foreach (step_events[i]) expected_events.insert(expected_events.size(), step_events[i]);
    endtask

    // Stimulus builders.
    task automatic add_byte(logic [7:0] c, bit last = 1'b0);
        req_t r;
        r.char_byte = c;
        r.end_of_text = last;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic add_string(string s, bit ends = 1'b1);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], ends && i == s.len() - 1);
        texts_sent += ends;
    endtask

    function automatic logic [7:0] rand_name_char();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0) return 8'(65 + $urandom_range(0, 25));
        if (k == 1) return 8'(97 + $urandom_range(0, 25));
        if (k == 2) return 8'(48 + $urandom_range(0, 9));
        return CH_UNDER;
    endfunction

    function automatic string rand_name(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            logic [7:0] ch;
            ch = rand_name_char();
            if (i == 0 && ch >= "0" && ch <= "9") ch = "t";
            s = {s, string'(ch)};
        end
        return s;
    endfunction

    // Build one nested text; some tags may be left unclosed and a small share gets corrupted.
    task automatic add_random_text();
        string s;
        string names[$];
        int steps;
        int len;
        logic [7:0] ch;
        s = "";
        steps = $urandom_range(1, 12);
        for (int i = 0; i < steps; i++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CH_OPEN || ch == CH_CLOSE) s = {s, string'(ch), string'(ch)};
                    else if (ch != 8'd0) s = {s, string'(ch)};
                end
                2, 3: if (names.size() < DEPTH) begin
                    len = ($urandom_range(0, 9) == 0) ? NAME_MAX : $urandom_range(1, 5);
                    names.insert(names.size(), rand_name(len));
                    s = {s, "[", names[$]};
                    if ($urandom_range(0, 2) == 0) s = {s, " a=1\tb  c"};
                    s = {s, "]"};
                end
                default: if (names.size() > 0) begin
                    s = {s, "[/", names[$], "]"};
                    names.delete(names.size() - 1);
                end
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            while (names.size() > 0) begin
                s = {s, "[/", names[$], "]"};
                names.delete(names.size() - 1);
            end
        if (s.len() == 0) s = "x";
        // Noise: overwrite one byte with any non-NUL byte.
        if ($urandom_range(0, 4) == 0)
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
        // NUL bytes are valid input too; send the bytes directly.
        for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
        if ($urandom_range(0, 19) == 0) add_byte(8'h00, 1'b1);
        texts_sent++;
    endtask

    initial
    begin
        string deep;
        // Directed: escapes, every event kind, every error, the depth and length limits.
        add_string("a[[b]]c");
        add_string("[b x=1  y]t[/b]");
        add_string("]x");
        add_string("]");
        add_string("[]");
        add_string("[1]");
        add_string("[a-]");
        add_string("[a][/a-]");
        add_string("[/a]");
        add_string("[a][/b]");
        add_string("[ab");
        add_string("[a]");
        add_string({"[", rand_name(NAME_MAX), "x]"});
        deep = "";
        for (int i = 0; i < DEPTH; i++) deep = {deep, "[q]"};
        add_string({deep, "[z]"});
        add_string("[a][/]");
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'h80, 1'b1);
        texts_sent++;
        while (pending_reqs.size() < 1100) add_random_text();
    end

    // Reset, then release.
    initial
    begin
        restart_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                predict_markup_events(req_data);
                void'(pending_reqs.pop_front());
            end
            if (req_valid && req_stall) begin
                // hold the stalled request
            end
            else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > (req_valid && !req_stall ? 0 : 0)) begin
                if (pending_reqs.size() == 0) req_valid <= 1'b0;
                else begin
                    req_valid <= 1'b1;
                    req_data <= pending_reqs[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else burst_left <= burst_left - 1;
                end
            end
            else req_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run.
    int stall_cycle = 0;
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        hold_off_now <= stall_cycle >= 300 && stall_cycle < 500;
        if (stall_cycle >= 300 && stall_cycle < 500) evt_stall <= 1'b1;
        else if ((stall_cycle / 64) % 3 == 0) evt_stall <= 1'b0;
        else evt_stall <= ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each accepted event with the oldest expectation.
    always @(posedge clk)
    begin
        evt_t want;
        if (rst_n && evt_valid && !evt_stall) begin
            events_seen <= events_seen + 1;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, actual %p", $time, evt_data);
                errors <= errors + 1;
            end
            else begin
                want = expected_events.pop_front();
                if (want !== evt_data) begin
                    $display("%0t: event mismatch, expected %p, actual %p",
                             $time, want, evt_data);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (evt_valid && !evt_stall) || hold_off_now)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d requests and %0d events outstanding",
                     pending_reqs.size(), expected_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n);
        wait (pending_reqs.size() == 0 && expected_events.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d texts, %0d events; escapes, params, nesting, all error codes",
                 texts_sent, events_seen);
        if (errors == 0 && expected_events.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/bbmp_pkg.sv
rtl/bbmp_ram.sv
rtl/bbmp_result_fifo.sv
rtl/bbcode_markup_parser_unit.sv
sim/tb_top.sv
